### rtl/core/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types and constants of the pulse beat rate detector: field widths,
// register indexes and reset values, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
package pbrd_pkg;

	// default widths of the input word
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF   = 32;

	// fixed field widths
	localparam int THR_BITS       = 12;
	localparam int MIN_BITS       = 16;
	localparam int RATE_BITS      = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;

	// beats per minute numerator, 60 s in milliseconds
	localparam logic [RATE_BITS-1:0] RATE_NUM = 16'd60000;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_THR = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_THR = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_IVAL  = 2'd2;

	// register reset values
	localparam logic [THR_BITS-1:0] UPPER_THR_RST = 12'd3800;
	localparam logic [THR_BITS-1:0] LOWER_THR_RST = 12'd3200;
	localparam logic [MIN_BITS-1:0] MIN_IVAL_RST  = 16'd300;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_PUSH
	} pbrd_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic rate_load;
		logic out_load;
	} pbrd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} pbrd_status_t;

endpackage

### rtl/core/pbrd_div.sv
// ----------------------------------------------------------------------------
// pbrd_div
// Restoring divider for 60000 / interval: one quotient bit per cycle,
// and done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module pbrd_div #(
	parameter int TIME_BITS = pbrd_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [TIME_BITS-1:0]           divisor,
	output logic                           done,
	output logic [pbrd_pkg::RATE_BITS-1:0] quotient
);
	import pbrd_pkg::*;

	localparam int CNT_BITS = $clog2(RATE_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [RATE_BITS-1:0] num_q;
	logic [RATE_BITS-1:0] quo_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] den_q;

	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS:0]   diff;
	logic                 fits;

	// one trial subtraction a step
	always_comb begin
		trial = {rem_q, num_q[RATE_BITS-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(RATE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			num_q <= RATE_NUM;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[RATE_BITS-2:0], 1'b0};
			rem_q <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[RATE_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	// checks
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

endmodule

### rtl/core/pbrd_dp.sv
// ----------------------------------------------------------------------------
// pbrd_dp
// Datapath: configuration registers, captured input word, hysteresis state,
// interval measurement, the rate divider and the output word register.
// ----------------------------------------------------------------------------
module pbrd_dp #(
	parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = pbrd_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pbrd_pkg::pbrd_cmd_t                cmd,
	output pbrd_pkg::pbrd_status_t             status,
	input  logic                               cfg_we,
	input  logic [pbrd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic [TIME_BITS-1:0]               time_ms,
	output logic [pbrd_pkg::RATE_BITS-1:0]     rate_bpm,
	output logic                               beat_found,
	output logic                               indicator
);
	import pbrd_pkg::*;

	localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

	logic [THR_BITS-1:0]    upper_q;
	logic [THR_BITS-1:0]    lower_q;
	logic [MIN_BITS-1:0]    min_q;

	logic [SAMPLE_BITS-1:0] smp_q;
	logic [TIME_BITS-1:0]   now_q;

	logic [TIME_BITS-1:0]   start_time_q;
	logic                   armed_q;
	logic                   complete_q;
	logic [RATE_BITS-1:0]   held_rate_q;
	logic                   ind_q;
	logic                   found_q;

	logic [RATE_BITS-1:0]   rate_bpm_q;
	logic                   beat_found_q;
	logic                   indicator_q;

	logic                   peak;
	logic                   relax;
	logic [TIME_BITS-1:0]   interval;
	logic                   accept_beat;
	logic                   armed_d;
	logic                   complete_d;
	logic                   restart;
	logic                   div_done;
	logic [RATE_BITS-1:0]   quotient;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_THR_RST;
			lower_q <= LOWER_THR_RST;
			min_q   <= MIN_IVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UPPER_THR: upper_q <= cfg_data[THR_BITS-1:0];
				REG_LOWER_THR: lower_q <= cfg_data[THR_BITS-1:0];
				REG_MIN_IVAL:  min_q   <= cfg_data[MIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// captured input word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q <= sample;
			now_q <= time_ms;
		end
	end

	// threshold tests and interval
	always_comb begin
		peak        = CMP_BITS'(smp_q) > CMP_BITS'(upper_q);
		relax       = CMP_BITS'(smp_q) < CMP_BITS'(lower_q);
		interval    = now_q - start_time_q;
		accept_beat = peak && complete_q && (interval > TIME_BITS'(min_q));
	end

	// next hysteresis state: peak test first, then relaxation test
	always_comb begin
		armed_d    = armed_q;
		complete_d = complete_q;
		restart    = 1'b0;
		if (peak && complete_q) begin
			armed_d    = 1'b0;
			complete_d = 1'b0;
		end
		if (peak && !armed_d) begin
			armed_d = 1'b1;
			restart = 1'b1;
		end
		if (relax && armed_d) begin
			complete_d = 1'b1;
		end
	end

	// hysteresis state and held rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			armed_q      <= 1'b0;
			complete_q   <= 1'b0;
			held_rate_q  <= '0;
			ind_q        <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			if (cmd.update) begin
				armed_q    <= armed_d;
				complete_q <= complete_d;
				found_q    <= accept_beat;
				if (restart) begin
					start_time_q <= now_q;
				end
				if (accept_beat) begin
					ind_q <= ~ind_q;
				end
			end
			if (cmd.rate_load) begin
				held_rate_q <= quotient;
			end
		end
	end

	// rate divider
	pbrd_div #(
		.TIME_BITS (TIME_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (interval),
		.done     (div_done),
		.quotient (quotient)
	);

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rate_bpm_q   <= held_rate_q;
			beat_found_q <= found_q;
			indicator_q  <= ind_q;
		end
	end

	assign status.need_div = accept_beat;
	assign status.div_done = div_done;
	assign rate_bpm        = rate_bpm_q;
	assign beat_found      = beat_found_q;
	assign indicator       = indicator_q;

	// checks
	a_rate_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.rate_load |=> $stable(held_rate_q))
		else $error("held rate changed without a divider result");

endmodule

### rtl/core/pbrd_ctrl.sv
// ----------------------------------------------------------------------------
// pbrd_ctrl
// Controller: takes one input word at a time, steps the datapath through
// evaluation and the optional division, and owns the output valid flag.
// ----------------------------------------------------------------------------
module pbrd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pbrd_pkg::pbrd_cmd_t    cmd,
	input  pbrd_pkg::pbrd_status_t status
);
	import pbrd_pkg::*;

	pbrd_state_t state_q;
	pbrd_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EVAL;
			S_EVAL: state_d = status.need_div ? S_DIV : S_PUSH;
			S_DIV:  if (status.div_done) state_d = S_PUSH;
			S_PUSH: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EVAL: begin
				cmd.update    = 1'b1;
				cmd.div_start = status.need_div;
			end
			S_DIV:  cmd.rate_load = status.div_done;
			S_PUSH: cmd.out_load  = out_free;
			default: ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_capture_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_EVAL)
		else $error("captured word not evaluated");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

endmodule

### rtl/core/pulse_beat_rate_detector_core.sv
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector_core
// Beat detector with two-threshold hysteresis and a beats per minute output.
//
// Usage:
//   in channel  (in_valid/in_ready): one word of sample and time_ms.
//   out channel (out_valid/out_ready): one word of rate_bpm, beat_found and
//     indicator for every input word, in order.
//   cfg channel (cfg_valid/cfg_ready): cfg_index 0 upper threshold, 1 lower
//     threshold, 2 minimum interval; other indexes are ignored. cfg_ready is
//     always high; write only while no word is in flight.
//   One word is worked on at a time. A word is captured on acceptance,
//     evaluated against the thresholds, and its result then registered in
//     the output word register, after which the next word can be accepted.
//     For a word that yields a beat, the restoring divider for 60000 /
//     interval runs after evaluation, one quotient bit per cycle, 16 in all.
//   The output word register holds its word while out_ready is low; the
//     next input word is still taken and evaluated, and waits for the
//     register to free before its own result is loaded.
//   Reset clears the hysteresis state, the held rate and the indicator, and
//     loads the register defaults 3800, 3200 and 300.
// ----------------------------------------------------------------------------
module pulse_beat_rate_detector_core #(
	parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = pbrd_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic [TIME_BITS-1:0]               time_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pbrd_pkg::RATE_BITS-1:0]     rate_bpm,
	output logic                               beat_found,
	output logic                               indicator,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pbrd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import pbrd_pkg::*;

	pbrd_cmd_t    cmd;
	pbrd_status_t status;
	logic         cfg_we;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// controller
	pbrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath
	pbrd_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.time_ms    (time_ms),
		.rate_bpm   (rate_bpm),
		.beat_found (beat_found),
		.indicator  (indicator)
	);

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pulse_beat_rate_detector_core. Words of sample and
// time_ms go in over a valid/ready channel. A behavioural beat detector in
// the bench predicts the rate, beat flag and indicator of every accepted
// word, and each result word is compared in order. A directed table comes
// first, followed by random pulse trains under several register settings
// and with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import pbrd_pkg::*;

	localparam int SMP_W         = SAMPLE_BITS_DEF;
	localparam int TIME_W        = TIME_BITS_DEF;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 205;

	// index with no register behind it
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [RATE_BITS-1:0] rate;
		logic                 found;
		logic                 ind;
	} beat_word_t;

	typedef enum logic {
		ROW_WORD,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] data;
		logic [SMP_W-1:0]         smp;
		logic [TIME_W-1:0]        tms;
		logic                     typed;
		logic [RATE_BITS-1:0]     want_rate;
		logic                     want_found;
		logic                     want_ind;
	} step_row_t;

	// directed table: typed results only where they are plain to see
	localparam int DIRECTED_ROWS = 32;
	localparam step_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// straight after reset, nothing armed
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'd0,    1'b1, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'd1000, 1'b1, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'd1100, 1'b1, 16'd0,  1'b0, 1'b0},
		// first beat, one second interval
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'd2000, 1'b1, 16'd60, 1'b1, 1'b1},
		// levels equal to the thresholds count as neither peak nor relaxed
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd3800, 32'd2100, 1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd3200, 32'd2150, 1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd3199, 32'd2200, 1'b0, 16'd0,  1'b0, 1'b0},
		// interval equal to the minimum is rejected
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd3801, 32'd2300, 1'b1, 16'd60, 1'b0, 1'b1},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd3000, 32'd2400, 1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4000, 32'd2601, 1'b0, 16'd0,  1'b0, 1'b0},
		// very long interval gives rate zero, then an interval across the wrap
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd100,  32'd2700, 1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'hFFFF_FF00, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'hFFFF_FF80, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'h0000_012C, 1'b0, 16'd0, 1'b0, 1'b0},
		// no minimum: zero interval still rejected, one millisecond is the top rate
		'{ROW_REG,  REG_MIN_IVAL,  16'h0000, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'h12C,  1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'h12C,  1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'h12D,  1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'h12D,  1'b1, 16'd60000, 1'b1, 1'b1},
		// largest minimum
		'{ROW_REG,  REG_MIN_IVAL,  16'hFFFF, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'h1000, 1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'h1012D, 1'b0, 16'd0, 1'b0, 1'b0},
		// lower above upper: arm and complete on one word
		'{ROW_REG,  REG_UPPER_THR, 16'hF064, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_REG,  REG_LOWER_THR, 16'h00C8, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_REG,  REG_MIN_IVAL,  16'd1000, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd150,  32'h20000, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd150,  32'h203E9, 1'b0, 16'd0, 1'b0, 1'b0},
		// spare index ignored, thresholds at the ends of their range
		'{ROW_REG,  REG_SPARE,     16'h0000, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_REG,  REG_UPPER_THR, 16'h0FFF, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_REG,  REG_LOWER_THR, 16'h0000, 12'd0,    32'd0,    1'b0, 16'd0,  1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd4095, 32'h30000, 1'b0, 16'd0, 1'b0, 1'b0},
		'{ROW_WORD, REG_UPPER_THR, 16'h0000, 12'd0,    32'h40000, 1'b0, 16'd0, 1'b0, 1'b0}
	};

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [SMP_W-1:0]         sample    = '0;
	logic [TIME_W-1:0]        time_ms   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [RATE_BITS-1:0]     rate_bpm;
	logic                     beat_found;
	logic                     indicator;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	// detector state mirrored by the bench
	logic [THR_BITS-1:0]  upper_thr       = UPPER_THR_RST;
	logic [THR_BITS-1:0]  lower_thr       = LOWER_THR_RST;
	logic [MIN_BITS-1:0]  min_ival        = MIN_IVAL_RST;
	logic [TIME_W-1:0]    start_time      = '0;
	logic                 timing_armed    = 1'b0;
	logic                 beat_complete   = 1'b0;
	logic [RATE_BITS-1:0] held_rate       = '0;
	logic                 indicator_level = 1'b0;

	beat_word_t expected_beats [$];
	beat_word_t oldest_beat;
	int         fault_count = 0;
	int         cycle_count = 0;
	int         send_gap_pct  = 0;
	int         recv_stall_pct = 0;

	pulse_beat_rate_detector_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.time_ms    (time_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rate_bpm   (rate_bpm),
		.beat_found (beat_found),
		.indicator  (indicator),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result word check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				fault_count <= fault_count + 1;
				if (fault_count < 10)
					$display("unexpected result word: rate %0d beat %0b ind %0b",
						rate_bpm, beat_found, indicator);
			end else begin
				oldest_beat = expected_beats.pop_front();
				if (rate_bpm !== oldest_beat.rate || beat_found !== oldest_beat.found
					|| indicator !== oldest_beat.ind) begin
					fault_count <= fault_count + 1;
					if (fault_count < 10)
						$display("mismatch: rate %0d/%0d beat %0b/%0b ind %0b/%0b (exp/got)",
							oldest_beat.rate, rate_bpm, oldest_beat.found, beat_found,
							oldest_beat.ind, indicator);
				end
			end
		end
	end

	// beat detector: peak test first, then relaxation test on the same sample
	task automatic predict_beat(input logic [SMP_W-1:0] s, input logic [TIME_W-1:0] t,
		output beat_word_t w);
		logic [TIME_W-1:0] span;
		logic              found;
		found = 1'b0;
		if (s > upper_thr) begin
			if (beat_complete) begin
				span = t - start_time;
				if (span > TIME_W'(min_ival) && span != '0) begin
					held_rate       = RATE_BITS'(TIME_W'(RATE_NUM) / span);
					indicator_level = ~indicator_level;
					found           = 1'b1;
				end
				timing_armed  = 1'b0;
				beat_complete = 1'b0;
			end
			if (!timing_armed) begin
				start_time   = t;
				timing_armed = 1'b1;
			end
		end
		if (s < lower_thr && timing_armed)
			beat_complete = 1'b1;
		w = '{held_rate, found, indicator_level};
	endtask

	// one input word, entered and left at a falling edge
	task automatic send_word(input logic [SMP_W-1:0] s, input logic [TIME_W-1:0] t,
		input logic typed, input beat_word_t typed_want);
		beat_word_t w;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		time_ms  <= t;
		do @(posedge clk); while (!in_ready);
		predict_beat(s, t, w);
		expected_beats.push_back(typed ? typed_want : w);
		@(negedge clk);
	endtask

	// wait for every word to come back and the block to settle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, mirrored into the bench copy on acceptance
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_UPPER_THR: begin
				upper_thr = data[THR_BITS-1:0];
			end
			REG_LOWER_THR: begin
				lower_thr = data[THR_BITS-1:0];
			end
			REG_MIN_IVAL: begin
				min_ival = data[MIN_BITS-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random thresholds and minimum, upper data bits scrambled, and at random a spare write
	task automatic random_setting();
		logic [THR_BITS-1:0] hi;
		logic [THR_BITS-1:0] lo;
		hi = THR_BITS'($urandom_range(1500, 4000));
		if ($urandom_range(0, 3) == 0)
			lo = THR_BITS'($urandom_range(hi, 4095));
		else
			lo = THR_BITS'($urandom_range(0, hi));
		write_reg(REG_UPPER_THR, {4'($urandom), hi});
		write_reg(REG_LOWER_THR, {4'($urandom), lo});
		write_reg(REG_MIN_IVAL, MIN_BITS'($urandom_range(0, 1200)));
		if ($urandom_range(0, 1) == 1)
			write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
	endtask

	initial begin
		beat_word_t        no_want;
		logic [SMP_W-1:0]  s;
		logic [TIME_W-1:0] now;
		int                pick;

		no_want = '0;
		now     = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				drain_block();
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				send_word(DIRECTED[i].smp, DIRECTED[i].tms, DIRECTED[i].typed,
					'{DIRECTED[i].want_rate, DIRECTED[i].want_found, DIRECTED[i].want_ind});
			end
		end

		// random pulse trains, one idling pattern per phase
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_block();
			case (p % 4)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 49;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 49;
				end
				default: begin
					send_gap_pct   = 21;
					recv_stall_pct = 21;
				end
			endcase
			random_setting();
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// timestamp: mostly steady steps, some repeats and jumps
				pick = $urandom_range(0, 99);
				if (pick < 4)
					now = TIME_W'($urandom);
				else if (pick >= 8)
					now = now + TIME_W'($urandom_range(1, 700));
				// level: peaks, troughs, the band between, and noise
				pick = $urandom_range(0, 99);
				if (pick < 40)
					s = (upper_thr < 12'hFFF) ? SMP_W'($urandom_range(upper_thr + 1, 4095))
						: 12'hFFF;
				else if (pick < 80)
					s = (lower_thr > 0) ? SMP_W'($urandom_range(0, lower_thr - 1)) : '0;
				else if (pick < 92)
					s = SMP_W'($urandom_range(lower_thr, upper_thr));
				else
					s = SMP_W'($urandom);
				send_word(s, now, 1'b0, no_want);
			end
		end

		drain_block();
		if (expected_beats.size() != 0)
			fault_count = fault_count + expected_beats.size();
		if (fault_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/pbrd_pkg.sv
rtl/core/pbrd_div.sv
rtl/core/pbrd_dp.sv
rtl/core/pbrd_ctrl.sv
rtl/core/pulse_beat_rate_detector_core.sv
tb/sv/testbench.sv
